### rtl/epcal_pkg.sv
`timescale 1ns / 1ps

package epcal_pkg;

   localparam int unsigned SecsCountWidth = 32;
   localparam int unsigned YearWidth      = 12;
   localparam int unsigned MonthWidth     = 4;
   localparam int unsigned DayWidth       = 5;
   localparam int unsigned HourWidth      = 5;
   localparam int unsigned MinuteWidth    = 6;
   localparam int unsigned SecondWidth    = 6;

   // days = (secs >> 7) / 675, exact for a 25-bit quotient input
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;
   localparam int unsigned DAY_SHIFT  = 35;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;

   // epoch JDN plus the 32044 offset of the date formula
   localparam logic [21:0] JDN_BIAS = 22'd2483589;

   // century split: 4a+3 crosses 68*146097 and 69*146097 at these a values,
   // which are also floor(146097*cent/4) for those centuries
   localparam logic [21:0] CENT_BASE_67 = 22'd2447124;
   localparam logic [21:0] CENT_BASE_68 = 22'd2483649;
   localparam logic [21:0] CENT_BASE_69 = 22'd2520173;

   localparam logic [17:0] QUAD_RECIP = 18'd183735;
   localparam logic [10:0] DAYS_4Y    = 11'd1461;

   localparam logic [13:0] HOUR_RECIP = 14'd9321;
   localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

   localparam logic [10:0] MONTH_RECIP = 11'd1714;
   localparam logic [10:0] MINUTE_RECIP = 11'd1093;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;

   localparam logic [3:0]  MSHIFT_WRAP = 4'd10;

   typedef enum logic [1:0] {
      CENT_67 = 2'd0,
      CENT_68 = 2'd1,
      CENT_69 = 2'd2
   } cent_type;

   // 100 * cent - 4800
   function automatic logic [YearWidth-1:0] cent_year_base(input cent_type cent);
      logic [YearWidth-1:0] base;
      base = 12'd1900;
      case (cent)
         CENT_67: base = 12'd1900;
         CENT_68: base = 12'd2000;
         CENT_69: base = 12'd2100;
         default: base = 12'd1900;
      endcase
      return base;
   endfunction

   // (153 * m + 2) / 5, days before the shifted month m
   function automatic logic [8:0] month_start_day(input logic [3:0] m);
      logic [8:0] d;
      d = 9'd0;
      case (m)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

### rtl/epoch_seconds_to_calendar_date.sv
`timescale 1ns / 1ps

// Converts an unsigned 32-bit count of seconds since 2000-01-01 00:00:00 into
// the Gregorian date (2000..2136) and time of day. The converter is a six-stage
// pipeline built around constant multipliers: busy stays low, an item may be
// started in every cycle, and each item's result passes through the stage
// registers in order and appears on the rsp_ ports with rsp_valid high for one
// cycle. Results come out in order and cannot be held off, so the receiver
// must take rsp_ whenever rsp_valid is high. Reset only clears the valid bits
// of the pipeline.

module epoch_seconds_to_calendar_date
   import epcal_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [SecsCountWidth-1:0] req_seconds_count,
   output logic                      rsp_valid,
   output logic [YearWidth-1:0]      rsp_year_value,
   output logic [MonthWidth-1:0]     rsp_month_value,
   output logic [DayWidth-1:0]       rsp_day_value,
   output logic [HourWidth-1:0]      rsp_hour_value,
   output logic [MinuteWidth-1:0]    rsp_minute_value,
   output logic [SecondWidth-1:0]    rsp_second_value
);

   logic        accept;

   // stage 1: whole days
   logic        v1_ff;
   logic [31:0] secs1_ff;
   logic [15:0] days1_ff, days1_in;
   logic [50:0] day_prod;

   // stage 2: seconds of day, century and day of century
   logic        v2_ff;
   logic [16:0] rem2_ff, rem2_in;
   logic [15:0] dayc2_ff, dayc2_in;
   cent_type    cent2_ff, cent2_in;
   logic [32:0] rem_prod;
   logic [31:0] rem_diff;
   logic [21:0] jdn_a, jdn_diff;

   // stage 3: quad-year and hour
   logic        v3_ff;
   logic [16:0] rem3_ff;
   logic [15:0] dayc3_ff;
   cent_type    cent3_ff;
   logic [6:0]  quad3_ff, quad3_in;
   logic [4:0]  hour3_ff, hour3_in;
   logic [35:0] quad_prod;
   logic [26:0] hour_prod;

   // stage 4: day of year and seconds of hour
   logic        v4_ff;
   cent_type    cent4_ff;
   logic [6:0]  quad4_ff;
   logic [4:0]  hour4_ff;
   logic [8:0]  dayq4_ff, dayq4_in;
   logic [11:0] remh4_ff, remh4_in;
   logic [17:0] quad_days;
   logic [15:0] dayq_diff;
   logic [16:0] hour_secs;
   logic [16:0] remh_diff;

   // stage 5: shifted month and minute
   logic        v5_ff;
   cent_type    cent5_ff;
   logic [6:0]  quad5_ff;
   logic [4:0]  hour5_ff;
   logic [8:0]  dayq5_ff;
   logic [11:0] remh5_ff;
   logic [3:0]  mshift5_ff, mshift5_in;
   logic [5:0]  minute5_ff, minute5_in;
   logic [10:0] month_arg;
   logic [21:0] month_prod;
   logic [20:0] minute_prod;

   // stage 6: result register
   logic                   v6_ff;
   logic [YearWidth-1:0]   year6_ff, year6_in;
   logic [MonthWidth-1:0]  month6_ff, month6_in;
   logic [DayWidth-1:0]    day6_ff, day6_in;
   logic [HourWidth-1:0]   hour6_ff;
   logic [MinuteWidth-1:0] minute6_ff;
   logic [SecondWidth-1:0] second6_ff, second6_in;
   logic                   wrap;
   logic [8:0]             day_diff;
   logic [11:0]            min_secs;
   logic [11:0]            sec_diff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      day_prod = 51'(req_seconds_count[31:7]) * 51'(DAY_RECIP);
      days1_in = day_prod[50:DAY_SHIFT];
   end

   always_comb begin
      rem_prod = 33'(days1_ff) * 33'(SECS_PER_DAY);
      rem_diff = secs1_ff - rem_prod[31:0];
      rem2_in  = rem_diff[16:0];
      jdn_a    = 22'(days1_ff) + JDN_BIAS;
      if (jdn_a >= CENT_BASE_69) begin
         cent2_in = CENT_69;
         jdn_diff = jdn_a - CENT_BASE_69;
      end else if (jdn_a >= CENT_BASE_68) begin
         cent2_in = CENT_68;
         jdn_diff = jdn_a - CENT_BASE_68;
      end else begin
         cent2_in = CENT_67;
         jdn_diff = jdn_a - CENT_BASE_67;
      end
      dayc2_in = jdn_diff[15:0];
   end

   always_comb begin
      quad_prod = 36'({dayc2_ff, 2'b11}) * 36'(QUAD_RECIP);
      quad3_in  = quad_prod[34:28];
      hour_prod = 27'(rem2_ff[16:4]) * 27'(HOUR_RECIP);
      hour3_in  = hour_prod[25:21];
   end

   always_comb begin
      quad_days = 18'(quad3_ff) * 18'(DAYS_4Y);
      dayq_diff = dayc3_ff - quad_days[17:2];
      dayq4_in  = dayq_diff[8:0];
      hour_secs = 17'(hour3_ff) * 17'(SECS_PER_HOUR);
      remh_diff = rem3_ff - hour_secs;
      remh4_in  = remh_diff[11:0];
   end

   always_comb begin
      month_arg   = 11'(dayq4_ff) * 11'd5 + 11'd2;
      month_prod  = 22'(month_arg) * 22'(MONTH_RECIP);
      mshift5_in  = month_prod[21:18];
      minute_prod = 21'(remh4_ff[11:2]) * 21'(MINUTE_RECIP);
      minute5_in  = minute_prod[19:14];
   end

   always_comb begin
      wrap       = (mshift5_ff >= MSHIFT_WRAP);
      day_diff   = dayq5_ff - month_start_day(mshift5_ff) + 9'd1;
      day6_in    = day_diff[DayWidth-1:0];
      month6_in  = wrap ? (mshift5_ff - 4'd9) : (mshift5_ff + 4'd3);
      year6_in   = cent_year_base(cent5_ff) + 12'(quad5_ff) + 12'(wrap);
      min_secs   = 12'(minute5_ff) * 12'(SECS_PER_MIN);
      sec_diff   = remh5_ff - min_secs;
      second6_in = sec_diff[SecondWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      secs1_ff   <= req_seconds_count;
      days1_ff   <= days1_in;

      rem2_ff    <= rem2_in;
      dayc2_ff   <= dayc2_in;
      cent2_ff   <= cent2_in;

      rem3_ff    <= rem2_ff;
      dayc3_ff   <= dayc2_ff;
      cent3_ff   <= cent2_ff;
      quad3_ff   <= quad3_in;
      hour3_ff   <= hour3_in;

      cent4_ff   <= cent3_ff;
      quad4_ff   <= quad3_ff;
      hour4_ff   <= hour3_ff;
      dayq4_ff   <= dayq4_in;
      remh4_ff   <= remh4_in;

      cent5_ff   <= cent4_ff;
      quad5_ff   <= quad4_ff;
      hour5_ff   <= hour4_ff;
      dayq5_ff   <= dayq4_ff;
      remh5_ff   <= remh4_ff;
      mshift5_ff <= mshift5_in;
      minute5_ff <= minute5_in;

      year6_ff   <= year6_in;
      month6_ff  <= month6_in;
      day6_ff    <= day6_in;
      hour6_ff   <= hour5_ff;
      minute6_ff <= minute5_ff;
      second6_ff <= second6_in;
   end

   assign rsp_valid        = v6_ff;
   assign rsp_year_value   = year6_ff;
   assign rsp_month_value  = month6_ff;
   assign rsp_day_value    = day6_ff;
   assign rsp_hour_value   = hour6_ff;
   assign rsp_minute_value = minute6_ff;
   assign rsp_second_value = second6_ff;

endmodule
